// ===== design/esdc_pkg.sv =====
// Package for the undirected edge coalescer: default sizes, controller command
// codes and the status group that the datapath returns to the controller.
// No dependencies.
package esdc_pkg;

    localparam int MAX_EDGES_DEF = 512;
    localparam int NODE_BITS_DEF = 24;
    localparam int ATTR_BITS_DEF = 32;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE       = 4'd0;
    localparam op_t OP_CAPTURE    = 4'd1;
    localparam op_t OP_LOAD_A     = 4'd2;
    localparam op_t OP_LOAD_B     = 4'd3;
    localparam op_t OP_SORT_START = 4'd4;
    localparam op_t OP_RUN_INIT   = 4'd5;
    localparam op_t OP_MERGE_RD   = 4'd6;
    localparam op_t OP_MERGE_WR   = 4'd7;
    localparam op_t OP_PASS_NEXT  = 4'd8;
    localparam op_t OP_DD_START   = 4'd9;
    localparam op_t OP_DD_RD      = 4'd10;
    localparam op_t OP_DD_WR      = 4'd11;
    localparam op_t OP_SORT_DONE  = 4'd12;
    localparam op_t OP_RD_ISSUE   = 4'd13;
    localparam op_t OP_EMIT       = 4'd14;

    typedef struct packed {
        logic func;
        logic closed;
        logic sorted;
        logic n_le1;
        logic n_zero;
        logic run_last;
        logic pass_last;
        logic sort_last;
        logic dd_last;
    } stat_t;

endpackage

// ===== design/esdc_ram.sv =====
// Simple dual-read memory: one write port, two registered read ports.
// No dependencies.
module esdc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== design/esdc_datapath.sv =====
// Datapath of the edge coalescer: two ping-pong edge memories, merge-sort and
// de-duplication pointers, set flags and the result register.
// Depends on esdc_pkg and esdc_ram.
module esdc_datapath #(
    parameter int MAX_EDGES = esdc_pkg::MAX_EDGES_DEF,
    parameter int NODE_BITS = esdc_pkg::NODE_BITS_DEF,
    parameter int ATTR_BITS = esdc_pkg::ATTR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  esdc_pkg::op_t        op,
    output esdc_pkg::stat_t      stat,
    input  logic                 func,
    input  logic [NODE_BITS-1:0] src_node,
    input  logic [NODE_BITS-1:0] dst_node,
    input  logic [ATTR_BITS-1:0] attr_bits,
    input  logic                 last_edge,
    output logic                 out_valid,
    output logic [NODE_BITS-1:0] out_row,
    output logic [NODE_BITS-1:0] out_col,
    output logic [ATTR_BITS-1:0] out_attr,
    output logic                 out_last,
    output logic                 overflow
);

    import esdc_pkg::*;

    localparam int DEPTH  = 2 * MAX_EDGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WID_W  = CNT_W + 1;
    localparam int SUM_W  = CNT_W + 2;
    localparam int KEY_W  = 2 * NODE_BITS;
    localparam int ENT_W  = KEY_W + ATTR_BITS;

    // Captured transaction
    logic                 func_reg;
    logic [NODE_BITS-1:0] src_reg;
    logic [NODE_BITS-1:0] dst_reg;
    logic [ATTR_BITS-1:0] attr_reg;
    logic                 last_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic             overflow_reg;
    logic             closed_reg;
    logic             sorted_reg;
    logic             fits_reg;
    logic             bank_reg;
    logic [WID_W-1:0] wid_reg;
    logic [CNT_W-1:0] base_reg;
    logic [CNT_W-1:0] li_reg;
    logic [CNT_W-1:0] lend_reg;
    logic [CNT_W-1:0] ri_reg;
    logic [CNT_W-1:0] rend_reg;
    logic [CNT_W-1:0] wr_reg;
    logic [KEY_W-1:0] last_key_reg;

    logic                 out_valid_reg;
    logic [NODE_BITS-1:0] out_row_reg;
    logic [NODE_BITS-1:0] out_col_reg;
    logic [ATTR_BITS-1:0] out_attr_reg;
    logic                 out_last_reg;
    logic                 out_ovf_reg;

    // Memory ports
    logic              we;
    logic              wbank;
    logic [ADDR_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [ENT_W-1:0]  r0_a;
    logic [ENT_W-1:0]  r0_b;
    logic [ENT_W-1:0]  r1_a;
    logic [ENT_W-1:0]  r1_b;
    logic [ENT_W-1:0]  rd_a;
    logic [ENT_W-1:0]  rd_b;
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;

    logic [CNT_W-1:0] eff_count;
    logic             fits_calc;
    logic [SUM_W-1:0] sum_l;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] n_ext;
    logic [CNT_W-1:0] lend_calc;
    logic [CNT_W-1:0] rend_calc;
    logic             left_ok;
    logic             right_ok;
    logic             take_left;
    logic             keep;
    logic             hit;

    assign rd_a  = bank_reg ? r1_a : r0_a;
    assign rd_b  = bank_reg ? r1_b : r0_b;
    assign key_a = rd_a[ENT_W-1:ATTR_BITS];
    assign key_b = rd_b[ENT_W-1:ATTR_BITS];

    // A new set starts when a load arrives after the previous one was closed.
    assign eff_count = closed_reg ? '0 : count_reg;
    assign fits_calc = ({1'b0, eff_count} + (CNT_W + 1)'(2)) <= (CNT_W + 1)'(DEPTH);

    assign n_ext     = SUM_W'(count_reg);
    assign sum_l     = SUM_W'(base_reg) + SUM_W'(wid_reg);
    assign sum_r     = SUM_W'(base_reg) + {wid_reg, 1'b0};
    assign lend_calc = (sum_l < n_ext) ? sum_l[CNT_W-1:0] : count_reg;
    assign rend_calc = (sum_r < n_ext) ? sum_r[CNT_W-1:0] : count_reg;

    // Stable merge: on equal keys the left run, inserted earlier, goes first.
    assign left_ok   = li_reg < lend_reg;
    assign right_ok  = ri_reg < rend_reg;
    assign take_left = left_ok && (!right_ok || (key_a <= key_b));

    assign keep = (li_reg == '0) || (key_a != last_key_reg);
    assign hit  = closed_reg && (rd_ptr_reg < count_reg);

    assign stat.func      = func_reg;
    assign stat.closed    = closed_reg;
    assign stat.sorted    = sorted_reg;
    assign stat.n_le1     = count_reg <= CNT_W'(1);
    assign stat.n_zero    = count_reg == '0;
    assign stat.run_last  = ({1'b0, wr_reg} + 1'b1) == {1'b0, rend_reg};
    assign stat.pass_last = rend_reg == count_reg;
    assign stat.sort_last = {1'b0, wid_reg, 1'b0} >= {1'b0, n_ext};
    assign stat.dd_last   = ({1'b0, li_reg} + 1'b1) == {1'b0, count_reg};

    always_comb
    begin
        we      = 1'b0;
        wbank   = 1'b0;
        waddr   = '0;
        wdata   = rd_a;
        re      = 1'b0;
        raddr_a = '0;
        raddr_b = '0;
        unique case (op)
            OP_LOAD_A:
            begin
                we    = fits_calc;
                waddr = eff_count[ADDR_W-1:0];
                wdata = {src_reg, dst_reg, attr_reg};
            end
            OP_LOAD_B:
            begin
                we    = fits_reg;
                waddr = ADDR_W'(count_reg + 1'b1);
                wdata = {dst_reg, src_reg, attr_reg};
            end
            OP_MERGE_RD:
            begin
                re      = 1'b1;
                raddr_a = li_reg[ADDR_W-1:0];
                raddr_b = ri_reg[ADDR_W-1:0];
            end
            OP_MERGE_WR:
            begin
                we    = 1'b1;
                wbank = ~bank_reg;
                waddr = wr_reg[ADDR_W-1:0];
                wdata = take_left ? rd_a : rd_b;
            end
            OP_DD_RD:
            begin
                re      = 1'b1;
                raddr_a = li_reg[ADDR_W-1:0];
            end
            OP_DD_WR:
            begin
                we    = keep;
                wbank = ~bank_reg;
                waddr = wr_reg[ADDR_W-1:0];
            end
            OP_RD_ISSUE:
            begin
                re      = 1'b1;
                raddr_a = rd_ptr_reg[ADDR_W-1:0];
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    esdc_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_ram0 (
        .clk     (clk),
        .we      (we && !wbank),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (r0_a),
        .rdata_b (r0_b)
    );

    esdc_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_ram1 (
        .clk     (clk),
        .we      (we && wbank),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (r1_a),
        .rdata_b (r1_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            overflow_reg <= 1'b0;
            closed_reg   <= 1'b0;
            sorted_reg   <= 1'b0;
            fits_reg     <= 1'b0;
            bank_reg     <= 1'b0;
            wid_reg      <= '0;
            base_reg     <= '0;
            li_reg       <= '0;
            lend_reg     <= '0;
            ri_reg       <= '0;
            rend_reg     <= '0;
            wr_reg       <= '0;
        end
        else
        begin
            unique case (op)
                OP_LOAD_A:
                begin
                    if (closed_reg)
                    begin
                        rd_ptr_reg <= '0;
                        sorted_reg <= 1'b0;
                        bank_reg   <= 1'b0;
                    end
                    count_reg    <= eff_count;
                    closed_reg   <= 1'b0;
                    fits_reg     <= fits_calc;
                    overflow_reg <= (overflow_reg && !closed_reg) || !fits_calc;
                end
                OP_LOAD_B:
                begin
                    if (fits_reg)
                    begin
                        count_reg <= count_reg + CNT_W'(2);
                    end
                    closed_reg <= last_reg;
                end
                OP_SORT_START:
                begin
                    wid_reg  <= WID_W'(1);
                    base_reg <= '0;
                end
                OP_RUN_INIT:
                begin
                    lend_reg <= lend_calc;
                    rend_reg <= rend_calc;
                    li_reg   <= base_reg;
                    ri_reg   <= lend_calc;
                    wr_reg   <= base_reg;
                end
                OP_MERGE_WR:
                begin
                    if (take_left)
                    begin
                        li_reg <= li_reg + 1'b1;
                    end
                    else
                    begin
                        ri_reg <= ri_reg + 1'b1;
                    end
                    wr_reg <= wr_reg + 1'b1;
                end
                OP_PASS_NEXT:
                begin
                    if (stat.pass_last)
                    begin
                        bank_reg <= ~bank_reg;
                        base_reg <= '0;
                        if (!stat.sort_last)
                        begin
                            wid_reg <= wid_reg << 1;
                        end
                    end
                    else
                    begin
                        base_reg <= rend_reg;
                    end
                end
                OP_DD_START:
                begin
                    li_reg <= '0;
                    wr_reg <= '0;
                end
                OP_DD_WR:
                begin
                    li_reg <= li_reg + 1'b1;
                    if (keep)
                    begin
                        wr_reg <= wr_reg + 1'b1;
                    end
                    if (stat.dd_last)
                    begin
                        count_reg <= keep ? wr_reg + 1'b1 : wr_reg;
                        bank_reg  <= ~bank_reg;
                    end
                end
                OP_SORT_DONE:
                begin
                    sorted_reg <= 1'b1;
                    rd_ptr_reg <= '0;
                end
                OP_EMIT:
                begin
                    if (hit)
                    begin
                        rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    end
                end
                default:
                begin
                    fits_reg <= fits_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_CAPTURE)
        begin
            func_reg <= func;
            src_reg  <= src_node;
            dst_reg  <= dst_node;
            attr_reg <= attr_bits;
            last_reg <= last_edge;
        end
        if (op == OP_DD_WR && keep)
        begin
            last_key_reg <= key_a;
        end
        if (op == OP_EMIT)
        begin
            out_valid_reg <= hit;
            out_row_reg   <= hit ? rd_a[ENT_W-1:ENT_W-NODE_BITS] : '0;
            out_col_reg   <= hit ? rd_a[KEY_W+ATTR_BITS-NODE_BITS-1:ATTR_BITS] : '0;
            out_attr_reg  <= hit ? rd_a[ATTR_BITS-1:0] : '0;
            out_last_reg  <= hit && (({1'b0, rd_ptr_reg} + 1'b1) == {1'b0, count_reg});
            out_ovf_reg   <= overflow_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_attr  = out_attr_reg;
    assign out_last  = out_last_reg;
    assign overflow  = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond store depth");

    a_merge_source: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_MERGE_WR |-> (left_ok || right_ok))
        else $error("merge step with both runs exhausted");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_reg |-> rd_ptr_reg <= count_reg)
        else $error("read pointer past the coalesced entries");

    a_sorted_closed: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_SORT_DONE |=> (closed_reg && sorted_reg))
        else $error("set marked sorted while open");

endmodule

// ===== design/esdc_ctrl.sv =====
// Controller of the edge coalescer: sequences loads, the merge sort passes,
// de-duplication and result reads, issuing one datapath command per cycle.
// Depends on esdc_pkg.
module esdc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            res_valid,
    input  logic            res_ready,
    input  esdc_pkg::stat_t stat,
    output esdc_pkg::op_t   op
);

    import esdc_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD_A   = 4'd1;
    localparam logic [3:0] S_LOAD_B   = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_SORT     = 4'd4;
    localparam logic [3:0] S_RUN_INIT = 4'd5;
    localparam logic [3:0] S_M_RD     = 4'd6;
    localparam logic [3:0] S_M_WR     = 4'd7;
    localparam logic [3:0] S_PASS     = 4'd8;
    localparam logic [3:0] S_DD_START = 4'd9;
    localparam logic [3:0] S_DD_RD    = 4'd10;
    localparam logic [3:0] S_DD_WR    = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;
    localparam logic [3:0] S_RD_ISSUE = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       slot_free;

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = res_valid_reg;
    assign slot_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_LOAD_A;
                end
            end
            S_LOAD_A:
            begin
                // The captured function code decides between a load and a read.
                if (stat.func)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    op         = OP_LOAD_A;
                    state_next = S_LOAD_B;
                end
            end
            S_LOAD_B:
            begin
                op         = OP_LOAD_B;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                if (!stat.closed)
                begin
                    state_next = S_EMIT;
                end
                else if (!stat.sorted)
                begin
                    state_next = S_SORT;
                end
                else
                begin
                    state_next = S_RD_ISSUE;
                end
            end
            S_SORT:
            begin
                op = OP_SORT_START;
                if (stat.n_zero)
                begin
                    state_next = S_FIN;
                end
                else if (stat.n_le1)
                begin
                    state_next = S_DD_START;
                end
                else
                begin
                    state_next = S_RUN_INIT;
                end
            end
            S_RUN_INIT:
            begin
                op         = OP_RUN_INIT;
                state_next = S_M_RD;
            end
            S_M_RD:
            begin
                op         = OP_MERGE_RD;
                state_next = S_M_WR;
            end
            S_M_WR:
            begin
                op         = OP_MERGE_WR;
                state_next = stat.run_last ? S_PASS : S_M_RD;
            end
            S_PASS:
            begin
                op = OP_PASS_NEXT;
                if (stat.pass_last && stat.sort_last)
                begin
                    state_next = S_DD_START;
                end
                else
                begin
                    state_next = S_RUN_INIT;
                end
            end
            S_DD_START:
            begin
                op         = OP_DD_START;
                state_next = S_DD_RD;
            end
            S_DD_RD:
            begin
                op         = OP_DD_RD;
                state_next = S_DD_WR;
            end
            S_DD_WR:
            begin
                op         = OP_DD_WR;
                state_next = stat.dd_last ? S_FIN : S_DD_RD;
            end
            S_FIN:
            begin
                op         = OP_SORT_DONE;
                state_next = S_RD_ISSUE;
            end
            S_RD_ISSUE:
            begin
                op         = OP_RD_ISSUE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    op             = OP_EMIT;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== design/edge_list_symmetrize_sort_dedup_core.sv =====
// Top level of the undirected edge coalescer: controller plus datapath.
// Depends on esdc_pkg, esdc_ctrl and esdc_datapath.
//
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    func, src_node, dst_node, attr_bits, last_edge
//  result   res_valid / res_ready  out_valid, out_row, out_col, out_attr, out_last, overflow
//
// A load accepts the edge, writes the forward copy, then the reversed one (one write port).
// A read decodes its function code and, on a closed set, issues a memory read and emits;
// on a still open set it emits an empty result without a read. Emitting waits for the
// result register to empty. The first read after a set closes also sorts: a bottom-up
// merge sort of the n stored entries in passes of doubling run width, then de-duplication.
// Reset clears only control state; the edge memories need no clearing pass.
// Loads go on while a result waits to be taken; a read waits for the result slot.
module edge_list_symmetrize_sort_dedup_core #(
    parameter int MAX_EDGES = esdc_pkg::MAX_EDGES_DEF,
    parameter int NODE_BITS = esdc_pkg::NODE_BITS_DEF,
    parameter int ATTR_BITS = esdc_pkg::ATTR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [NODE_BITS-1:0] src_node,
    input  logic [NODE_BITS-1:0] dst_node,
    input  logic [ATTR_BITS-1:0] attr_bits,
    input  logic                 last_edge,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 out_valid,
    output logic [NODE_BITS-1:0] out_row,
    output logic [NODE_BITS-1:0] out_col,
    output logic [ATTR_BITS-1:0] out_attr,
    output logic                 out_last,
    output logic                 overflow
);

    import esdc_pkg::*;

    op_t   op;
    stat_t stat;

    esdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .op        (op)
    );

    esdc_datapath #(
        .MAX_EDGES (MAX_EDGES),
        .NODE_BITS (NODE_BITS),
        .ATTR_BITS (ATTR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .func      (func),
        .src_node  (src_node),
        .dst_node  (dst_node),
        .attr_bits (attr_bits),
        .last_edge (last_edge),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_attr  (out_attr),
        .out_last  (out_last),
        .overflow  (overflow)
    );

endmodule
